FILE: sv/cccpt_pkg.sv
package cccpt_pkg;

    // Field and datapath widths
    localparam int NUM_PTS   = 4;
    localparam int NUM_TERMS = 4;
    localparam int REG_W     = 64;
    localparam int T_W       = 17;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = 48;              // Q4.12 entry times Q16.16 coordinate
    localparam int CSUM_W    = PROD_W + 2;      // four products summed
    localparam int COEF_W    = CSUM_W - 12;     // coefficient after rounding to Q.16
    localparam int TPROD_W   = COEF_W + T_W + 1;
    localparam int SUM_W     = 58;              // polynomial sums before the final shift
    localparam int SHR_W     = SUM_W - 16;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // Register indexes of the configuration port
    localparam logic [3:0] CFG_BASIS0 = 4'd0;
    localparam logic [3:0] CFG_BASIS1 = 4'd1;
    localparam logic [3:0] CFG_BASIS2 = 4'd2;
    localparam logic [3:0] CFG_BASIS3 = 4'd3;
    localparam logic [3:0] CFG_POINT0 = 4'd4;
    localparam logic [3:0] CFG_POINT1 = 4'd5;
    localparam logic [3:0] CFG_POINT2 = 4'd6;
    localparam logic [3:0] CFG_POINT3 = 4'd7;

    localparam logic signed [SHR_W-1:0] SAT_MAX = 42'sh0007FFFFFFF;
    localparam logic signed [SHR_W-1:0] SAT_MIN = -42'sh00080000000;

    typedef logic signed [COEF_W-1:0] t_coef;

    // Load enables of the six pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_stage_en;

    // Powers of t leaving the third stage
    typedef struct packed {
        logic [T_W-1:0] t;
        logic [T_W-1:0] t2;
        logic [T_W-1:0] t3;
        logic           t_zero;
        logic           t_one;
    } t_pow;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SHR_W-1:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[OUT_W-1:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[OUT_W-1:0];
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/cccpt_coef.sv
module cccpt_coef
    import cccpt_pkg::*;
(
    input  logic             i_clk,
    input  logic [REG_W-1:0] i_basis [NUM_PTS],
    input  logic [REG_W-1:0] i_point [NUM_PTS],
    output t_coef            o_coef_x [NUM_TERMS],
    output t_coef            o_coef_y [NUM_TERMS]
);

    logic signed [PROD_W-1:0] r_prod [2][NUM_TERMS][NUM_PTS];
    logic signed [CSUM_W-1:0] n_sum  [2][NUM_TERMS];
    t_coef                    r_coef [2][NUM_TERMS];

    // Form every basis entry times coordinate product
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                for (int i = 0; i < NUM_PTS; i++) begin
                    r_prod[a][k][i] <= PROD_W'($signed(i_basis[i][16*k +: 16])
                                              * $signed(i_point[i][32*a +: 32]));
                end
            end
        end
    end

    // Sum over the points and round Q.28 to Q.16
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                n_sum[a][k] = CSUM_W'(r_prod[a][k][0]) + CSUM_W'(r_prod[a][k][1])
                            + CSUM_W'(r_prod[a][k][2]) + CSUM_W'(r_prod[a][k][3])
                            + CSUM_W'(2048);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                r_coef[a][k] <= n_sum[a][k][CSUM_W-1:12];
            end
        end
    end

    assign o_coef_x = r_coef[0];
    assign o_coef_y = r_coef[1];

endmodule

FILE: sv/cccpt_pow.sv
module cccpt_pow
    import cccpt_pkg::*;
(
    input  logic           i_clk,
    input  t_stage_en      i_en,
    input  logic [T_W-1:0] i_param_t,
    output t_pow           o_pow
);

    logic [T_W-1:0] r1_t, r2_t, r3_t;
    logic [T_W-1:0] r2_t2, r3_t2, r3_t3;
    logic           r1_zero, r2_zero, r3_zero;
    logic           r1_one, r2_one, r3_one;
    logic [2*T_W-1:0] n_sq;
    logic [2*T_W-1:0] n_cube;

    // Stage 1: clamp t to one and flag the end points
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_t    <= (i_param_t > T_ONE) ? T_ONE : i_param_t;
            r1_zero <= (i_param_t == '0);
            r1_one  <= (i_param_t >= T_ONE);
        end
    end

    // Stage 2: t squared, rounded to Q1.16
    assign n_sq = (2*T_W)'(r1_t) * (2*T_W)'(r1_t) + (2*T_W)'(32768);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_t    <= r1_t;
            r2_t2   <= n_sq[T_W+15:16];
            r2_zero <= r1_zero;
            r2_one  <= r1_one;
        end
    end

    // Stage 3: t cubed from the rounded square
    assign n_cube = (2*T_W)'(r2_t2) * (2*T_W)'(r2_t) + (2*T_W)'(32768);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_t    <= r2_t;
            r3_t2   <= r2_t2;
            r3_t3   <= n_cube[T_W+15:16];
            r3_zero <= r2_zero;
            r3_one  <= r2_one;
        end
    end

    assign o_pow = '{t: r3_t, t2: r3_t2, t3: r3_t3, t_zero: r3_zero, t_one: r3_one};

endmodule

FILE: sv/cccpt_axis.sv
module cccpt_axis
    import cccpt_pkg::*;
(
    input  logic                    i_clk,
    input  t_stage_en               i_en,
    input  t_pow                    i_pow,
    input  t_coef                   i_coef [NUM_TERMS],
    input  logic signed [OUT_W-1:0] i_p0,
    input  logic signed [OUT_W-1:0] i_p3,
    output logic signed [OUT_W-1:0] o_pos,
    output logic signed [OUT_W-1:0] o_slope
);

    logic signed [T_W:0]         t_s, t2_s, t3_s;
    logic signed [TPROD_W-1:0]   r4_c1t, r4_c2t, r4_c2t2, r4_c3t2, r4_c3t3;
    logic                        r4_zero, r4_one, r5_zero, r5_one;
    logic signed [SUM_W-1:0]     n_pos_sum, n_slope_sum;
    logic signed [SUM_W-1:0]     r5_pos_sum, r5_slope_sum;
    logic signed [SHR_W-1:0]     pos_shr, slope_shr;
    logic signed [OUT_W-1:0]     r6_pos, r6_slope;

    assign t_s  = $signed({1'b0, i_pow.t});
    assign t2_s = $signed({1'b0, i_pow.t2});
    assign t3_s = $signed({1'b0, i_pow.t3});

    // Stage 4: coefficient times power of t
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_c1t  <= TPROD_W'(i_coef[1] * t_s);
            r4_c2t  <= TPROD_W'(i_coef[2] * t_s);
            r4_c2t2 <= TPROD_W'(i_coef[2] * t2_s);
            r4_c3t2 <= TPROD_W'(i_coef[3] * t2_s);
            r4_c3t3 <= TPROD_W'(i_coef[3] * t3_s);
            r4_zero <= i_pow.t_zero;
            r4_one  <= i_pow.t_one;
        end
    end

    // Stage 5: add up the point and slope polynomials with rounding
    always_comb begin
        n_pos_sum = (SUM_W'(i_coef[0]) <<< 16) + SUM_W'(r4_c1t) + SUM_W'(r4_c2t2)
                  + SUM_W'(r4_c3t3) + SUM_W'(32768);
        n_slope_sum = (SUM_W'(i_coef[1]) <<< 16) + (SUM_W'(r4_c2t) <<< 1)
                    + (SUM_W'(r4_c3t2) <<< 1) + SUM_W'(r4_c3t2) + SUM_W'(32768);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r5_pos_sum   <= n_pos_sum;
            r5_slope_sum <= n_slope_sum;
            r5_zero      <= r4_zero;
            r5_one       <= r4_one;
        end
    end

    // Stage 6: drop the fraction, saturate, substitute the end points for the position
    assign pos_shr   = r5_pos_sum[SUM_W-1:16];
    assign slope_shr = r5_slope_sum[SUM_W-1:16];

    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            if (r5_zero) begin
                r6_pos <= i_p0;
            end else if (r5_one) begin
                r6_pos <= i_p3;
            end else begin
                r6_pos <= sat32(pos_shr);
            end
            r6_slope <= sat32(slope_shr);
        end
    end

    assign o_pos   = r6_pos;
    assign o_slope = r6_slope;

endmodule

FILE: sv/cubic_curve_point_and_tangent_core.sv
// Cubic curve point and tangent core. Each transfer of a curve parameter t (unsigned
// Q1.16, values above 1.0 clamp to 1.0) returns the curve point and its derivative
// with respect to t, all signed Q16.16 and saturated to 32 bits. The block takes one
// t per clock while the output is not stalled. Three stages build t, t^2 and t^3, one
// stage multiplies them by the coefficients, one adds with rounding, one drops the
// fraction and saturates. The polynomial coefficients are computed from the basis
// rows and control points by a separate two-stage unit that runs at all times; after
// a register write they settle before an item taken with the write or later reaches
// the stages that use them. At t equal to 0 or 1.0 the point is P0 or P3 exactly.
module cubic_curve_point_and_tangent_core
    import cccpt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [3:0]              i_cfg_idx,
    input  logic [REG_W-1:0]        i_cfg_data,
    // parameter input
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [T_W-1:0]          i_param_t,
    // result output
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_pos_x,
    output logic signed [OUT_W-1:0] o_pos_y,
    output logic signed [OUT_W-1:0] o_slope_x,
    output logic signed [OUT_W-1:0] o_slope_y
);

    localparam int NSTG = 6;

    logic [REG_W-1:0] r_basis [NUM_PTS];
    logic [REG_W-1:0] r_point [NUM_PTS];
    logic [NSTG-1:0]  r_v;
    logic [NSTG:0]    rdy;
    t_stage_en        en;
    t_pow             pow;
    t_coef            coef_x [NUM_TERMS];
    t_coef            coef_y [NUM_TERMS];

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PTS; i++) begin
                r_basis[i] <= REG_W'(64'h1000 << (16 * i));
                r_point[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASIS0: r_basis[0] <= i_cfg_data;
                CFG_BASIS1: r_basis[1] <= i_cfg_data;
                CFG_BASIS2: r_basis[2] <= i_cfg_data;
                CFG_BASIS3: r_basis[3] <= i_cfg_data;
                CFG_POINT0: r_point[0] <= i_cfg_data;
                CFG_POINT1: r_point[1] <= i_cfg_data;
                CFG_POINT2: r_point[2] <= i_cfg_data;
                CFG_POINT3: r_point[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the one after it advances
    always_comb begin
        rdy[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0] && i_rst_n;
    assign o_valid = r_v[NSTG-1];

    always_comb begin
        en.s1 = rdy[0] && i_valid;
        en.s2 = rdy[1] && r_v[0];
        en.s3 = rdy[2] && r_v[1];
        en.s4 = rdy[3] && r_v[2];
        en.s5 = rdy[4] && r_v[3];
        en.s6 = rdy[5] && r_v[4];
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    cccpt_coef u_coef (
        .i_clk    (i_clk),
        .i_basis  (r_basis),
        .i_point  (r_point),
        .o_coef_x (coef_x),
        .o_coef_y (coef_y)
    );

    cccpt_pow u_pow (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_param_t (i_param_t),
        .o_pow     (pow)
    );

    cccpt_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pow   (pow),
        .i_coef  (coef_x),
        .i_p0    ($signed(r_point[0][31:0])),
        .i_p3    ($signed(r_point[3][31:0])),
        .o_pos   (o_pos_x),
        .o_slope (o_slope_x)
    );

    cccpt_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pow   (pow),
        .i_coef  (coef_y),
        .i_p0    ($signed(r_point[0][63:32])),
        .i_p3    ($signed(r_point[3][63:32])),
        .o_pos   (o_pos_y),
        .o_slope (o_slope_y)
    );

    // A full pipeline with a stalled output must refuse input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && !i_ready |-> !o_ready)
        else $error("input taken while pipeline full and stalled");

    // An input transfer lands in the first stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v[0])
        else $error("accepted item missing from first stage");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Output drains when nothing follows it
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !r_v[NSTG-2] |=> !o_valid)
        else $error("result repeated after transfer");

endmodule
